>>> design/swp_pkg.sv
// Package with the shared types and constants of the sparse wavefront profile unit.
`default_nettype none
package swp_pkg;

	localparam int IDX_W       = 10;
	localparam int ORDER_W     = 11;
	localparam int WF_W        = 12;
	localparam int SQ_W        = 2 * WF_W;
	localparam int MAXWF_W     = 11;
	localparam int MEAN_W      = 21;
	localparam int ROOT_W      = 11;
	localparam int BAND_W      = 10;
	localparam int DEF_MAX_ROWS = 1024;
	localparam int FIFO_DEPTH  = 4;

	localparam logic [ORDER_W-1:0] ORDER_RESET = 11'd1024;
	localparam logic [ORDER_W-1:0] MIN_NONE    = 11'h7FF;
	localparam logic [MAXWF_W-1:0] MAXWF_SAT   = 11'h7FF;
	localparam logic [MEAN_W-1:0]  MEAN_SAT    = 21'h1FFFFF;
	localparam logic [WF_W-1:0]    WF_ONE      = 12'd1;
	localparam logic [WF_W-1:0]    WF_MINUS_ONE = 12'hFFF;

	typedef struct packed {
		logic [IDX_W-1:0] row_index;
		logic [IDX_W-1:0] col_index;
		logic             row_done;
		logic             matrix_done;
	} swp_item_t;

	typedef struct packed {
		logic [MAXWF_W-1:0] peak_wavefront;
		logic [MEAN_W-1:0]  mean_square_wavefront;
		logic [ROOT_W-1:0]  wavefront_root;
		logic [BAND_W-1:0]  bandwidth;
	} swp_result_t;

	// Work handed from the front to the back through the queue.
	typedef struct packed {
		logic              do_close;
		logic              do_end;
		logic [IDX_W-1:0]  min_col;
		logic [IDX_W-1:0]  row;
		logic [BAND_W-1:0] band;
	} swp_cmd_t;

	typedef struct packed {
		logic              done;
		logic [MEAN_W-1:0] mean;
		logic [ROOT_W-1:0] root;
	} swp_stats_rsp_t;

	typedef enum logic [2:0] {
		BK_INIT,
		BK_IDLE,
		BK_RD_LO,
		BK_RD_HI,
		BK_WR_HI,
		BK_WALK,
		BK_DRAIN,
		BK_STATS
	} swp_back_state_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_ROOT
	} swp_stats_state_t;

endpackage
`default_nettype wire

>>> design/sparse_wavefront_profile_unit.sv
// Top level of the sparse wavefront profile unit.
// Nonzero entries of a square sparse matrix arrive in row order on the item
// port; a transfer takes place at a rising edge with start high and busy low.
// The front end takes one entry per cycle while busy is low and posts row
// closes and matrix ends into a four-deep queue. The back end handles a row
// close against a difference store in steps: pop, read low, read high with
// write low, then write high, so a run of closes fills the queue and busy then
// opens for one entry per close retired. A matrix end makes the back end walk
// the store from entry 0 through entry n, or through the highest entry written
// since the last walk if that is higher, zeroing as it goes, then drain the
// accumulator, divide the sum of squares by n and take the square root. The
// result is shown with result_valid for one cycle; the receiver cannot stall
// it. Entries keep flowing into the queue during the walk until it fills. After
// reset the store is cleared, entries 0 through MAX_ROWS, with busy high. The
// order register, reset to 1024, takes a write in any cycle and must only
// change while no matrix end is in progress.
`default_nettype none
module sparse_wavefront_profile_unit
	import swp_pkg::*;
#(
	parameter int MAX_ROWS = DEF_MAX_ROWS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire swp_item_t          item,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [ORDER_W-1:0] cfg_data,
	output logic                    result_valid,
	output swp_result_t             result
);

	// Width that holds any row count up to MAX_ROWS; also the store address width.
	localparam int CNT_W = $clog2(MAX_ROWS + 1);
	// Sum of squared 12-bit wavefronts over up to MAX_ROWS rows.
	localparam int SUM_W = SQ_W + CNT_W;

	logic [ORDER_W-1:0] rows_q;
	logic [CNT_W-1:0]   n_eff;
	logic               accept;
	logic               fifo_push;
	logic               fifo_pop;
	logic               fifo_empty;
	logic               fifo_full;
	swp_cmd_t           front_cmd;
	swp_cmd_t           fifo_head;
	logic               init_busy;
	logic               stats_start;
	logic [SUM_W-1:0]   stats_sum;
	swp_stats_rsp_t     stats_rsp;

	// The order register takes a write transfer in any cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ORDER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			rows_q <= cfg_data;
		end
	end

	// A zero order reads as one, and an order above the store size is clamped to it.
	always_comb begin
		if (rows_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (32'(rows_q) > MAX_ROWS) begin
			n_eff = CNT_W'(MAX_ROWS);
		end else begin
			n_eff = CNT_W'(rows_q);
		end
	end

	assign busy   = fifo_full | init_busy;
	assign accept = start & ~busy;

	swp_front #(
		.CNT_W (CNT_W)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.n_eff  (n_eff),
		.push   (fifo_push),
		.cmd    (front_cmd)
	);

	swp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fifo_push),
		.push_data (front_cmd),
		.pop       (fifo_pop),
		.head      (fifo_head),
		.empty     (fifo_empty),
		.full      (fifo_full)
	);

	swp_back #(
		.MAX_ROWS (MAX_ROWS),
		.CNT_W    (CNT_W),
		.SUM_W    (SUM_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.n_eff        (n_eff),
		.fifo_empty   (fifo_empty),
		.fifo_head    (fifo_head),
		.fifo_pop     (fifo_pop),
		.init_busy    (init_busy),
		.stats_start  (stats_start),
		.stats_sum    (stats_sum),
		.stats_rsp    (stats_rsp),
		.result_valid (result_valid),
		.result       (result)
	);

	swp_stats #(
		.SUM_W (SUM_W),
		.CNT_W (CNT_W)
	) u_stats (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (stats_start),
		.sum     (stats_sum),
		.divisor (n_eff),
		.rsp     (stats_rsp)
	);

	// A result is a single-cycle strobe.
	a_result_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe held for more than one cycle");

	// The front end never posts into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_push |-> !fifo_full)
		else $error("command queue overflow");

	// The back end only pops when a command is waiting.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_pop |-> !fifo_empty)
		else $error("command queue underflow");

	// No entry is taken while the store is still being cleared after reset.
	a_init_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> !accept)
		else $error("entry accepted during the clearing pass");

endmodule
`default_nettype wire

>>> design/swp_front.sv
// Front end: takes entries, tracks the open row's smallest column and the band.
`default_nettype none
module swp_front
	import swp_pkg::*;
#(
	parameter int CNT_W = 11
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire swp_item_t        item,
	input  wire logic [CNT_W-1:0] n_eff,
	output logic                  push,
	output swp_cmd_t              cmd
);

	logic [ORDER_W-1:0] min_col_q;
	logic [BAND_W-1:0]  band_q;
	logic [ORDER_W-1:0] new_min;
	logic               closing;
	logic               close_ok;
	logic [BAND_W-1:0]  row_band;
	logic [BAND_W-1:0]  new_band;

	always_comb begin
		new_min = ({1'b0, item.col_index} < min_col_q) ? {1'b0, item.col_index} : min_col_q;
		closing = item.row_done | item.matrix_done;
		close_ok = closing && (new_min <= {1'b0, item.row_index})
			&& (32'(item.row_index) < 32'(n_eff));
		row_band = item.row_index - new_min[IDX_W-1:0];
		new_band = (close_ok && (row_band > band_q)) ? row_band : band_q;
		push = accept & (close_ok | item.matrix_done);
		cmd.do_close = close_ok;
		cmd.do_end   = item.matrix_done;
		cmd.min_col  = new_min[IDX_W-1:0];
		cmd.row      = item.row_index;
		cmd.band     = new_band;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_col_q <= MIN_NONE;
			band_q    <= '0;
		end else if (accept) begin
			min_col_q <= closing ? MIN_NONE : new_min;
			band_q    <= item.matrix_done ? '0 : new_band;
		end
	end

endmodule
`default_nettype wire

>>> design/swp_fifo.sv
// Short command queue between the front end and the back end.
`default_nettype none
module swp_fifo
	import swp_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire swp_cmd_t push_data,
	input  wire logic     pop,
	output swp_cmd_t      head,
	output logic          empty,
	output logic          full
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);

	swp_cmd_t           slot_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (PTR_W+1)'(FIFO_DEPTH));
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

>>> design/swp_stats.sv
// Sequential divider and integer square root for the mean-square result.
`default_nettype none
module swp_stats
	import swp_pkg::*;
#(
	parameter int SUM_W = 35,
	parameter int CNT_W = 11
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [SUM_W-1:0] sum,
	input  wire logic [CNT_W-1:0] divisor,
	output swp_stats_rsp_t        rsp
);

	localparam int STEP_W = $clog2(SUM_W + 1);

	swp_stats_state_t   state_q, state_d;
	logic [SUM_W-1:0]   num_q;
	logic [CNT_W-1:0]   rem_q;
	logic [STEP_W-1:0]  step_q;
	logic [CNT_W:0]     rem_shift;
	logic               rem_ge;
	logic [MEAN_W-1:0]  mean_sat;
	logic [MEAN_W-1:0]  v_q;
	logic [MEAN_W:0]    res_q;
	logic [MEAN_W:0]    bit_q;
	logic [MEAN_W:0]    trial;
	logic               div_last;
	logic               root_last;
	logic               done_q;
	logic [MEAN_W-1:0]  mean_q;

	always_comb begin
		rem_shift = {rem_q, num_q[SUM_W-1]};
		rem_ge    = (rem_shift >= {1'b0, divisor});
		div_last  = (step_q == STEP_W'(SUM_W - 1));
		// Final quotient including this cycle's bit, saturated to the mean width.
		mean_sat  = (|num_q[SUM_W-2:MEAN_W-1]) ? MEAN_SAT : {num_q[MEAN_W-2:0], rem_ge};
		trial     = res_q + bit_q;
		root_last = (bit_q == (MEAN_W+1)'(1));
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_last) begin
					state_d = ST_ROOT;
				end
			end
			ST_ROOT: begin
				if (root_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_ROOT) && root_last;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				num_q  <= sum;
				rem_q  <= '0;
				step_q <= '0;
			end
			ST_DIV: begin
				// Restoring division, one quotient bit per cycle shifted into num_q.
				rem_q  <= rem_ge ? CNT_W'(rem_shift - {1'b0, divisor}) : rem_shift[CNT_W-1:0];
				num_q  <= {num_q[SUM_W-2:0], rem_ge};
				step_q <= step_q + STEP_W'(1);
				if (div_last) begin
					// The saturated quotient becomes the root's working value.
					v_q    <= mean_sat;
					mean_q <= mean_sat;
					res_q  <= '0;
					bit_q  <= (MEAN_W+1)'(1) << (MEAN_W - 1);
				end
			end
			ST_ROOT: begin
				if ({1'b0, v_q} >= trial) begin
					v_q   <= MEAN_W'({1'b0, v_q} - trial);
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			default: begin
			end
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.mean = mean_q;
	assign rsp.root = res_q[ROOT_W-1:0];

endmodule
`default_nettype wire

>>> design/swp_back.sv
// Back end: difference store updates, the store walk and the result register.
`default_nettype none
module swp_back
	import swp_pkg::*;
#(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int CNT_W    = 11,
	parameter int SUM_W    = 35
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [CNT_W-1:0] n_eff,
	input  wire logic             fifo_empty,
	input  wire swp_cmd_t         fifo_head,
	output logic                  fifo_pop,
	output logic                  init_busy,
	output logic                  stats_start,
	output logic [SUM_W-1:0]      stats_sum,
	input  wire swp_stats_rsp_t   stats_rsp,
	output logic                  result_valid,
	output swp_result_t           result
);

	swp_back_state_t   state_q, state_d;
	swp_cmd_t          cmd_q;
	logic [WF_W-1:0]   mem [0:MAX_ROWS];
	logic [WF_W-1:0]   rdata_q;
	logic              mem_we;
	logic [CNT_W-1:0]  mem_wa;
	logic [CNT_W-1:0]  mem_ra;
	logic [WF_W-1:0]   mem_wd;
	logic [CNT_W-1:0]  idx_q;
	logic              walk_begin;
	logic              walk_read;
	logic              pipe_busy;
	logic              rd_vld_s1;
	logic              vld_s2;
	logic              vld_s3;
	logic [WF_W-1:0]   run_q;
	logic [WF_W-1:0]   max_q;
	logic [SQ_W-1:0]   sq_s3;
	logic [SUM_W-1:0]  sum_q;
	logic              result_valid_q;
	swp_result_t       result_q;
	logic [CNT_W-1:0]  lo_addr;
	logic [CNT_W-1:0]  hi_addr;
	logic [CNT_W-1:0]  top_q;
	logic [CNT_W-1:0]  walk_last;

	assign lo_addr   = CNT_W'(cmd_q.min_col);
	assign hi_addr   = CNT_W'(cmd_q.row) + CNT_W'(1);
	assign pipe_busy = rd_vld_s1 | vld_s2 | vld_s3;
	// The walk also clears entries left above the order if it was lowered mid-matrix.
	assign walk_last = (top_q > n_eff) ? top_q : n_eff;

	always_comb begin
		state_d     = state_q;
		fifo_pop    = 1'b0;
		mem_we      = 1'b0;
		mem_wa      = idx_q;
		mem_wd      = '0;
		mem_ra      = idx_q;
		walk_begin  = 1'b0;
		walk_read   = 1'b0;
		stats_start = 1'b0;
		case (state_q)
			BK_INIT: begin
				mem_we = 1'b1;
				if (idx_q == CNT_W'(MAX_ROWS)) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (!fifo_empty) begin
					fifo_pop = 1'b1;
					if (fifo_head.do_close) begin
						state_d = BK_RD_LO;
					end else if (fifo_head.do_end) begin
						state_d    = BK_WALK;
						walk_begin = 1'b1;
					end
				end
			end
			BK_RD_LO: begin
				mem_ra  = lo_addr;
				state_d = BK_RD_HI;
			end
			BK_RD_HI: begin
				mem_ra  = hi_addr;
				mem_we  = 1'b1;
				mem_wa  = lo_addr;
				mem_wd  = rdata_q + WF_ONE;
				state_d = BK_WR_HI;
			end
			BK_WR_HI: begin
				mem_we = 1'b1;
				mem_wa = hi_addr;
				mem_wd = rdata_q + WF_MINUS_ONE;
				if (cmd_q.do_end) begin
					state_d    = BK_WALK;
					walk_begin = 1'b1;
				end else begin
					state_d = BK_IDLE;
				end
			end
			BK_WALK: begin
				// Entries 0 through walk_last are read and zeroed; only 0 to n-1 count.
				mem_we    = 1'b1;
				walk_read = (idx_q < n_eff);
				if (idx_q == walk_last) begin
					state_d = BK_DRAIN;
				end
			end
			BK_DRAIN: begin
				if (!pipe_busy) begin
					stats_start = 1'b1;
					state_d     = BK_STATS;
				end
			end
			BK_STATS: begin
				if (stats_rsp.done) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= BK_INIT;
			idx_q          <= '0;
			top_q          <= '0;
			rd_vld_s1      <= 1'b0;
			vld_s2         <= 1'b0;
			vld_s3         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			rd_vld_s1      <= walk_read;
			vld_s2         <= rd_vld_s1;
			vld_s3         <= vld_s2;
			result_valid_q <= (state_q == BK_STATS) && stats_rsp.done;
			if (walk_begin) begin
				idx_q <= '0;
			end else if (state_q == BK_INIT || state_q == BK_WALK) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			// Highest store entry written since the last walk.
			if (state_q == BK_WR_HI && hi_addr > top_q) begin
				top_q <= hi_addr;
			end else if (state_q == BK_WALK && idx_q == walk_last) begin
				top_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rdata_q <= mem[mem_ra];
	end

	always_ff @(posedge clk) begin
		if (fifo_pop) begin
			cmd_q <= fifo_head;
		end
		if (walk_begin) begin
			run_q <= '0;
			max_q <= '0;
			sum_q <= '0;
		end else begin
			if (rd_vld_s1) begin
				run_q <= run_q + rdata_q;
			end
			if (vld_s2) begin
				sq_s3 <= run_q * run_q;
				if (run_q > max_q) begin
					max_q <= run_q;
				end
			end
			if (vld_s3) begin
				sum_q <= sum_q + SUM_W'(sq_s3);
			end
		end
		if ((state_q == BK_STATS) && stats_rsp.done) begin
			result_q.peak_wavefront        <= max_q[WF_W-1] ? MAXWF_SAT : max_q[MAXWF_W-1:0];
			result_q.mean_square_wavefront <= stats_rsp.mean;
			result_q.wavefront_root        <= stats_rsp.root;
			result_q.bandwidth             <= cmd_q.band;
		end
	end

	assign init_busy    = (state_q == BK_INIT);
	assign stats_sum    = sum_q;
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire

>>> tb/sparse_wavefront_profile_unit_tb.sv
// Self-checking testbench for the sparse wavefront profile unit.
`timescale 1ns / 1ps
module sparse_wavefront_profile_unit_tb;
	import swp_pkg::*;

	localparam int ROWS_CAP = DEF_MAX_ROWS;
	localparam int COL_TOP = (1 << IDX_W) - 1;
	// A matrix end walks up to ROWS_CAP+1 store entries, drains the accumulator,
	// then divides and takes the root, after any queued row closes ahead of it.
	localparam int TAIL_CYCLES = ROWS_CAP + 200;
	localparam int DRAIN_LIMIT = 20000;
	localparam int ENTRY_TARGET = 1450;
	localparam int PHASE_ENTRIES = 160;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	swp_item_t item;
	logic cfg_valid;
	logic cfg_ready;
	logic [ORDER_W-1:0] cfg_data;
	logic result_valid;
	swp_result_t result;

	// Shadow copy of the block's state, kept in step with every accepted entry.
	logic [WF_W-1:0] wave_delta [0:ROWS_CAP];
	logic [ORDER_W-1:0] open_min_col;
	logic [BAND_W-1:0] band_so_far;
	logic [ORDER_W-1:0] order_reg;

	// Profiles still owed by the block, oldest first.
	swp_result_t profile_q[$];

	int fail_count;
	int entries_sent;
	int burst_left;

	sparse_wavefront_profile_unit #(
		.MAX_ROWS(ROWS_CAP)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.result(result)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The order register clamps: zero acts as one, anything past the store
	// size acts as the store size.
	function automatic int order_in_effect();
		if (order_reg == '0) return 1;
		if (int'(order_reg) > ROWS_CAP) return ROWS_CAP;
		return int'(order_reg);
	endfunction

	// Applies one entry to the shadow state. Returns 1 and fills the profile
	// when the entry ends the matrix.
	function automatic bit predict_profile(input swp_item_t it, output swp_result_t prof);
		int n;
		int peak;
		logic [WF_W-1:0] run;
		logic [IDX_W-1:0] low_col;
		longint unsigned sq_sum;
		longint unsigned mean;
		logic [ROOT_W-1:0] root;
		logic [ROOT_W-1:0] trial;
		prof = '0;
		if ({1'b0, it.col_index} < open_min_col) open_min_col = {1'b0, it.col_index};
		// A matrix end closes the open row even without its own row flag. The row
		// is closed under the index of the closing entry, whatever rows fed the
		// smallest column since the last close.
		if (it.row_done || it.matrix_done) begin
			low_col = open_min_col[IDX_W-1:0];
			// Rows past the order and rows whose columns all lie right of the
			// diagonal leave the store and the band untouched.
			if (int'(it.row_index) < order_in_effect() &&
					open_min_col <= {1'b0, it.row_index}) begin
				wave_delta[low_col] = wave_delta[low_col] + WF_ONE;
				wave_delta[int'(it.row_index) + 1] =
					wave_delta[int'(it.row_index) + 1] + WF_MINUS_ONE;
				if (it.row_index - low_col > band_so_far)
					band_so_far = it.row_index - low_col;
			end
			open_min_col = MIN_NONE;
		end
		if (!it.matrix_done) return 1'b0;

		// Prefix sums of the difference store give the per-row wavefront, which
		// wraps at twelve bits like the store itself.
		n = order_in_effect();
		run = '0;
		peak = 0;
		sq_sum = 0;
		for (int i = 0; i < n; i++) begin
			run = run + wave_delta[i];
			if (int'(run) > peak) peak = int'(run);
			sq_sum += 64'(run) * 64'(run);
		end
		mean = sq_sum / longint'(n);
		if (mean > 64'(MEAN_SAT)) mean = 64'(MEAN_SAT);
		if (peak > int'(MAXWF_SAT)) peak = int'(MAXWF_SAT);

		// Floor square root, one result bit at a time from the top.
		root = '0;
		for (int b = ROOT_W - 1; b >= 0; b--) begin
			trial = root | (ROOT_W'(1) << b);
			if (64'(trial) * 64'(trial) <= mean) root = trial;
		end

		prof.peak_wavefront = peak[MAXWF_W-1:0];
		prof.mean_square_wavefront = mean[MEAN_W-1:0];
		prof.wavefront_root = root;
		prof.bandwidth = band_so_far;

		foreach (wave_delta[i]) wave_delta[i] = '0;
		open_min_col = MIN_NONE;
		band_so_far = '0;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string field, input longint unsigned want,
			input longint unsigned got);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
	endtask

	// Every result strobe is one transfer; the oldest pending profile must match.
	always @(posedge clk) begin : result_check
		swp_result_t want;
		if (arst_n && result_valid) begin
			if (profile_q.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: profile result with none pending", $time);
			end else begin
				want = profile_q.pop_front();
				if (result.peak_wavefront !== want.peak_wavefront)
					report_mismatch("peak_wavefront", 64'(want.peak_wavefront),
						64'(result.peak_wavefront));
				if (result.mean_square_wavefront !== want.mean_square_wavefront)
					report_mismatch("mean_square_wavefront",
						64'(want.mean_square_wavefront),
						64'(result.mean_square_wavefront));
				if (result.wavefront_root !== want.wavefront_root)
					report_mismatch("wavefront_root", 64'(want.wavefront_root),
						64'(result.wavefront_root));
				if (result.bandwidth !== want.bandwidth)
					report_mismatch("bandwidth", 64'(want.bandwidth),
						64'(result.bandwidth));
			end
		end
	end

	// Offers one entry and holds it until a transfer. Entered and left at a
	// falling edge; start stays high on return so that back-to-back entries
	// need no second assignment in one step. The gap before the entry is drawn
	// here, with occasional bursts of zero-gap entries.
	task automatic send_entry(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
			input bit row_end, input bit matrix_end);
		swp_item_t it;
		swp_result_t want;
		int gap;
		it.row_index = row;
		it.col_index = col;
		it.row_done = row_end;
		it.matrix_done = matrix_end;
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else if ($urandom_range(0, 15) == 0) begin
			burst_left = $urandom_range(10, 40);
			gap = 0;
		end else begin
			gap = $urandom_range(0, 14);
		end
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		item = it;
		do @(posedge clk); while (busy);
		if (predict_profile(it, want)) profile_q.push_back(want);
		entries_sent++;
		@(negedge clk);
	endtask

	// Writes the order register; the shadow copy follows at the transfer.
	task automatic write_order(input logic [ORDER_W-1:0] value);
		cfg_valid = 1'b1;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		order_reg = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Stops offering entries, waits for every pending profile, then lets the
	// back end finish any row closes that produce no result.
	task automatic wait_until_idle();
		int guard;
		guard = 0;
		start = 1'b0;
		while (profile_q.size() != 0 && guard < DRAIN_LIMIT) begin
			@(negedge clk);
			guard++;
		end
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	// At the reset order: row and column at both ends of their range, a close
	// that reaches the last store entry, and a matrix end without a row flag.
	task automatic test_field_extremes();
		send_entry(0, 0, 1'b1, 1'b0);
		send_entry(COL_TOP, 0, 1'b1, 1'b0);
		send_entry(COL_TOP, COL_TOP, 1'b0, 1'b1);
	endtask

	// Columns from earlier unclosed rows fold into the next close.
	task automatic test_row_closed_by_index();
		wait_until_idle();
		write_order(16);
		send_entry(2, 1, 1'b0, 1'b0);
		send_entry(4, 6, 1'b1, 1'b0);
		send_entry(6, 3, 1'b0, 1'b1);
	endtask

	// Rows whose smallest column is right of the diagonal add nothing.
	task automatic test_column_above_row();
		send_entry(1, 9, 1'b1, 1'b0);
		send_entry(3, 3, 1'b1, 1'b0);
		send_entry(5, 8, 1'b0, 1'b1);
	endtask

	// With a small order, rows past it are dropped and the walk is short.
	task automatic test_row_outside_order();
		wait_until_idle();
		write_order(4);
		send_entry(2, 0, 1'b1, 1'b0);
		send_entry(6, 1, 1'b1, 1'b0);
		send_entry(9, 9, 1'b0, 1'b1);
	endtask

	// Zero acts as an order of one; all ones acts as the full store.
	task automatic test_order_out_of_range();
		wait_until_idle();
		write_order('0);
		send_entry(0, 0, 1'b0, 1'b1);
		wait_until_idle();
		write_order('1);
		send_entry(0, 0, 1'b1, 1'b0);
		send_entry(COL_TOP, 512, 1'b0, 1'b1);
	endtask

	// One row closed several times stacks its wavefront.
	task automatic test_repeated_closes();
		wait_until_idle();
		write_order(8);
		send_entry(3, 0, 1'b1, 1'b0);
		send_entry(3, 2, 1'b1, 1'b0);
		send_entry(3, 3, 1'b1, 1'b0);
		send_entry(3, 1, 1'b1, 1'b0);
		send_entry(3, 0, 1'b1, 1'b0);
		send_entry(7, 2, 1'b1, 1'b0);
		send_entry(7, 7, 1'b1, 1'b1);
	endtask

	// One random matrix at the current order. Most are well formed: increasing
	// rows inside the order, one close per row. The rest jump past the order,
	// drop or add row flags, and may end without closing the last row.
	task automatic send_random_matrix();
		int eff;
		int limit;
		int rows;
		int stride;
		int r;
		int entries;
		int sel;
		bit clean;
		bit row_end;
		logic [IDX_W-1:0] col;
		int row_list[$];
		eff = order_in_effect();
		clean = ($urandom_range(0, 9) != 0);
		limit = clean ? eff - 1 : COL_TOP;
		rows = $urandom_range(1, 12);
		stride = eff / rows;
		r = $urandom_range(0, stride < limit ? stride : limit);
		while (row_list.size() < rows && r <= limit) begin
			row_list.push_back(r);
			r += 1 + $urandom_range(0, stride);
			if (!clean && $urandom_range(0, 3) == 0) r += $urandom_range(0, COL_TOP);
		end
		foreach (row_list[i]) begin
			entries = $urandom_range(1, 3);
			for (int e = 0; e < entries; e++) begin
				// Mostly on or left of the diagonal, sometimes anywhere.
				sel = $urandom_range(0, 9);
				if (sel < 6) col = IDX_W'($urandom_range(0, row_list[i]));
				else if (sel < 9) col = IDX_W'($urandom_range(0, COL_TOP));
				else col = IDX_W'(row_list[i]);
				row_end = (e == entries - 1);
				if (!clean && $urandom_range(0, 3) == 0) row_end = !row_end;
				send_entry(IDX_W'(row_list[i]), col, row_end,
					i == row_list.size() - 1 && e == entries - 1);
			end
		end
	endtask

	// Phases of random matrices, each at its own order. The first phases take
	// the extremes of the register; later ones favor small orders so that
	// matrix-end walks stay short, with the odd large one.
	task automatic test_random_matrices();
		int phase;
		int phase_end;
		logic [ORDER_W-1:0] order_pick;
		phase = 0;
		while (entries_sent < ENTRY_TARGET) begin
			case (phase)
				0: order_pick = 1;
				1: order_pick = '1;
				2: order_pick = '0;
				3: order_pick = ORDER_RESET;
				default: begin
					if ($urandom_range(0, 3) != 0)
						order_pick = ORDER_W'($urandom_range(2, 64));
					else
						order_pick = ORDER_W'($urandom_range(65, 2047));
				end
			endcase
			wait_until_idle();
			write_order(order_pick);
			phase_end = entries_sent + PHASE_ENTRIES;
			while (entries_sent < phase_end && entries_sent < ENTRY_TARGET)
				send_random_matrix();
			phase++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		fail_count = 0;
		entries_sent = 0;
		burst_left = 0;
		foreach (wave_delta[i]) wave_delta[i] = '0;
		open_min_col = MIN_NONE;
		band_so_far = '0;
		order_reg = ORDER_RESET;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The block clears its store after reset with busy high; the first
		// entry simply waits for it.
		test_field_extremes();
		test_row_closed_by_index();
		test_column_above_row();
		test_row_outside_order();
		test_order_out_of_range();
		test_repeated_closes();
		test_random_matrices();

		wait_until_idle();
		if (profile_q.size() != 0) begin
			fail_count += profile_q.size();
			$display("%0d profile results never arrived", profile_q.size());
		end
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Hard stop well past the slowest legal run, where every entry ends a
	// matrix at the full store size.
	initial begin
		#100000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
